>>> hw/rtl/rme_pkg.sv
// Shared types and constants for the register machine execute core.
// Holds the opcode and status codes, instruction field positions and the
// request struct passed from the sequencer to the multiply/divide unit.
package rme_pkg;

    // Instruction field positions: op[15:12], ra[11:8], rb[7:4], rd[3:0], imm[7:0]
    localparam int INSTR_W  = 16;
    localparam int FIELD_W  = 4;
    localparam int IMM_W    = 8;
    localparam int OP_LSB   = 12;
    localparam int RA_LSB   = 8;
    localparam int RB_LSB   = 4;
    localparam int RD_LSB   = 0;
    localparam int STATUS_W = 3;
    localparam int RESULT_W = 64;

    typedef enum logic [FIELD_W-1:0] {
        OP_LDIMM  = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_DIV    = 4'd3,
        OP_MUL    = 4'd4,
        OP_MOVRES = 4'd5,
        OP_DONE   = 4'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXEC    = 3'd0,
        ST_DONE    = 3'd1,
        ST_DIVZ    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    // Command bit values
    localparam logic CMD_EXECUTE = 1'b0;
    localparam logic CMD_RESET   = 1'b1;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage

>>> hw/rtl/register_machine_execute_core.sv
// Top level of the register machine execute core: sequencer, result
// register, halt flag and output register around rme_regfile and rme_muldiv.
// Depends on rme_pkg, rme_regfile and rme_muldiv.
//
//  Channel | Ports                              | Direction | Moves
//  --------+------------------------------------+-----------+-----------------------------
//  input   | s_valid s_ready s_command          | in        | one command or instruction
//          | s_instruction                      |           | item
//  result  | m_valid m_ready m_status           | out       | one status / result item
//          | m_result_value                     |           | per input item
//
// Sequence: a reset command or an instruction while halted is accepted, then
// answered. Other instructions are accepted with the register file read,
// executed with write-back, then answered. MUL and a DIV by a nonzero divisor
// hold the sequencer while the bit-serial unit iterates one bit per cycle.
// Reset: aresetn (synchronous, active low) clears the sequencer, halt flag,
// result register, output valid and the register file valid bits.
// Stalls: the result waits in its own output register; the sequencer holds
// in its respond state only while that register is still full and unread.
module register_machine_execute_core #(
    parameter int DATA_WIDTH = 64,
    parameter int REG_COUNT  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [rme_pkg::INSTR_W-1:0]      s_instruction,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rme_pkg::STATUS_W-1:0]     m_status,
    output logic [rme_pkg::RESULT_W-1:0]     m_result_value
);
    import rme_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_RESP
    } state_t;

    state_t                state_reg;
    status_t               status_reg;
    op_t                   op_reg;
    logic [FIELD_W-1:0]    ra_reg;
    logic [FIELD_W-1:0]    rd_reg;
    logic [IMM_W-1:0]      imm_reg;
    logic                  halted_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [RESULT_W-1:0]   m_result_reg;

    logic                  accept;
    logic                  rf_clear;
    logic                  rf_rd_en;
    logic [DATA_WIDTH-1:0] rf_a;
    logic [DATA_WIDTH-1:0] rf_b;
    logic                  rf_wr_en;
    logic [FIELD_W-1:0]    rf_wr_idx;
    logic [DATA_WIDTH-1:0] rf_wr_data;
    md_req_t               md_req;
    logic                  md_done;
    logic [DATA_WIDTH-1:0] md_result;
    logic                  out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Clear the register file valid bits on a reset command
    assign rf_clear = accept && (s_command == CMD_RESET);
    // Read both source registers as an instruction is accepted while not halted
    assign rf_rd_en = accept && (s_command == CMD_EXECUTE) && !halted_reg;

    // Write-back: immediate and ALU ops in execute, MUL/DIV when the unit ends
    always_comb begin
        rf_wr_en   = 1'b0;
        rf_wr_idx  = rd_reg;
        rf_wr_data = rf_a + rf_b;
        md_req     = '0;
        if (state_reg == S_EXEC) begin
            case (op_reg)
                OP_LDIMM: begin
                    rf_wr_en   = 1'b1;
                    rf_wr_idx  = ra_reg;
                    rf_wr_data = DATA_WIDTH'(imm_reg);
                end
                OP_ADD: begin
                    rf_wr_en   = 1'b1;
                    rf_wr_data = rf_a + rf_b;
                end
                OP_SUB: begin
                    rf_wr_en   = 1'b1;
                    rf_wr_data = rf_a - rf_b;
                end
                OP_DIV: begin
                    md_req.start  = (rf_b != '0);
                    md_req.is_div = 1'b1;
                end
                OP_MUL: begin
                    md_req.start  = 1'b1;
                    md_req.is_div = 1'b0;
                end
                default: begin
                    rf_wr_en = 1'b0;
                end
            endcase
        end else if (state_reg == S_WAIT && md_done) begin
            rf_wr_en   = 1'b1;
            rf_wr_data = md_result;
        end
    end

    rme_regfile #(
        .DATA_WIDTH (DATA_WIDTH),
        .REG_COUNT  (REG_COUNT)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (rf_clear),
        .rd_en     (rf_rd_en),
        .rd_idx_a  (s_instruction[RA_LSB +: FIELD_W]),
        .rd_idx_b  (s_instruction[RB_LSB +: FIELD_W]),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b),
        .wr_en     (rf_wr_en),
        .wr_idx    (rf_wr_idx),
        .wr_data   (rf_wr_data)
    );

    rme_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .opa     (rf_a),
        .opb     (rf_b),
        .done    (md_done),
        .result  (md_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            halted_reg   <= 1'b0;
            result_reg   <= '0;
            m_valid_reg  <= 1'b0;
            status_reg   <= ST_EXEC;
            m_status_reg <= ST_EXEC;
        end else begin
            // Drop the output item once taken; the respond state reloads it itself
            if (m_valid_reg && m_ready && state_reg != S_RESP) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg  <= op_t'(s_instruction[OP_LSB +: FIELD_W]);
                        ra_reg  <= s_instruction[RA_LSB +: FIELD_W];
                        rd_reg  <= s_instruction[RD_LSB +: FIELD_W];
                        imm_reg <= s_instruction[IMM_W-1:0];
                        if (s_command == CMD_RESET) begin
                            halted_reg <= 1'b0;
                            result_reg <= '0;
                            status_reg <= ST_EXEC;
                            state_reg  <= S_RESP;
                        end else if (halted_reg) begin
                            status_reg <= ST_IGNORED;
                            state_reg  <= S_RESP;
                        end else begin
                            status_reg <= ST_EXEC;
                            state_reg  <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    state_reg <= S_RESP;
                    case (op_reg)
                        OP_LDIMM, OP_ADD, OP_SUB: begin
                            status_reg <= ST_EXEC;
                        end
                        OP_DIV: begin
                            if (rf_b == '0) begin
                                halted_reg <= 1'b1;
                                status_reg <= ST_DIVZ;
                            end else begin
                                state_reg <= S_WAIT;
                            end
                        end
                        OP_MUL: begin
                            state_reg <= S_WAIT;
                        end
                        OP_MOVRES: begin
                            result_reg <= rf_a;
                        end
                        OP_DONE: begin
                            halted_reg <= 1'b1;
                            status_reg <= ST_DONE;
                        end
                        default: begin
                            halted_reg <= 1'b1;
                            status_reg <= ST_UNKNOWN;
                        end
                    endcase
                end
                S_WAIT: begin
                    // Hold until the bit-serial unit has written back
                    if (md_done) begin
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    // Load the output register when it is empty or being taken
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_result_reg <= RESULT_W'(result_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_value = m_result_reg;

endmodule

>>> hw/rtl/rme_regfile.sv
// Register file of the register machine: one synchronous memory, two read
// ports with registered outputs, one write port, and per-entry valid bits.
// Depends on rme_pkg for the index width.
module rme_regfile #(
    parameter int DATA_WIDTH = 64,
    parameter int REG_COUNT  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear,
    input  logic                           rd_en,
    input  logic [rme_pkg::FIELD_W-1:0]    rd_idx_a,
    input  logic [rme_pkg::FIELD_W-1:0]    rd_idx_b,
    output logic [DATA_WIDTH-1:0]          rd_data_a,
    output logic [DATA_WIDTH-1:0]          rd_data_b,
    input  logic                           wr_en,
    input  logic [rme_pkg::FIELD_W-1:0]    wr_idx,
    input  logic [DATA_WIDTH-1:0]          wr_data
);
    import rme_pkg::*;

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [DATA_WIDTH-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]  vld_reg;
    logic [DATA_WIDTH-1:0] data_a_reg;
    logic [DATA_WIDTH-1:0] data_b_reg;
    logic                  hit_a_reg;
    logic                  hit_b_reg;
    logic                  in_a;
    logic                  in_b;
    logic                  in_w;

    // Indexes at or above REG_COUNT read as zero and drop writes
    assign in_a = {1'b0, rd_idx_a} < (FIELD_W + 1)'(REG_COUNT);
    assign in_b = {1'b0, rd_idx_b} < (FIELD_W + 1)'(REG_COUNT);
    assign in_w = {1'b0, wr_idx}   < (FIELD_W + 1)'(REG_COUNT);

    always_ff @(posedge aclk) begin
        if (wr_en && in_w) begin
            mem[wr_idx[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            data_a_reg <= mem[rd_idx_a[IDX_W-1:0]];
            data_b_reg <= mem[rd_idx_b[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            vld_reg   <= '0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            if (wr_en && in_w) begin
                vld_reg[wr_idx[IDX_W-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                hit_a_reg <= in_a && vld_reg[rd_idx_a[IDX_W-1:0]];
                hit_b_reg <= in_b && vld_reg[rd_idx_b[IDX_W-1:0]];
            end
        end
    end

    // Entries never written since the last clear read as zero
    assign rd_data_a = hit_a_reg ? data_a_reg : '0;
    assign rd_data_b = hit_b_reg ? data_b_reg : '0;

endmodule

>>> hw/rtl/rme_muldiv.sv
// Iterative multiply / unsigned divide unit, one bit per cycle.
// Shift-add multiply (modulo 2^DATA_WIDTH) and restoring division.
// Depends on rme_pkg for the request struct.
module rme_muldiv #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rme_pkg::md_req_t       req,
    input  logic [DATA_WIDTH-1:0]  opa,
    input  logic [DATA_WIDTH-1:0]  opb,
    output logic                   done,
    output logic [DATA_WIDTH-1:0]  result
);
    import rme_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] acc_reg;   // product or remainder
    logic [DATA_WIDTH-1:0] a_reg;     // multiplicand or dividend/quotient
    logic [DATA_WIDTH-1:0] b_reg;     // multiplier or divisor

    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   diff;

    assign rem_shift = {acc_reg, a_reg[DATA_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            div_reg <= req.is_div;
            acc_reg <= '0;
            a_reg   <= opa;
            b_reg   <= opb;
        end else if (busy_reg) begin
            if (div_reg) begin
                // Keep the trial difference when it does not borrow
                if (!diff[DATA_WIDTH]) begin
                    acc_reg <= diff[DATA_WIDTH-1:0];
                end else begin
                    acc_reg <= rem_shift[DATA_WIDTH-1:0];
                end
                a_reg <= {a_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            end else begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= {a_reg[DATA_WIDTH-2:0], 1'b0};
                b_reg <= {1'b0, b_reg[DATA_WIDTH-1:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = div_reg ? a_reg : acc_reg;

endmodule

>>> tb/register_machine_execute_core_test.sv
`timescale 1ns / 100ps
// Testbench for register_machine_execute_core: directed and random instruction items
// are checked against a predictor of the register file, result register and halt flag.
// Depends on rme_pkg and the core RTL only.
module register_machine_execute_core_test;
    import rme_pkg::*;

    // Opcodes past DONE are unknown and must halt the machine.
    localparam logic [FIELD_W-1:0] OP_FIRST_UNKNOWN = 4'd7;
    localparam logic [FIELD_W-1:0] OP_LAST_UNKNOWN  = 4'hF;

    localparam int REG_SLOTS    = 16;
    localparam int TARGET_ITEMS = 1600;  // input items over the whole run, directed included
    localparam int IDLE_LIMIT   = 5000;  // cycles with no item moving on either channel
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for the backpressure test
    localparam int DRAIN_CYCLES = 100;   // settle time once outstanding responses have drained

    typedef struct {
        status_t              status;
        logic [RESULT_W-1:0]  value;
    } machine_result_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_command     = CMD_EXECUTE;
    logic [INSTR_W-1:0]    s_instruction = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [RESULT_W-1:0]   m_result_value;

    // Predicted machine state, updated as each item is accepted.
    logic [RESULT_W-1:0]   model_regs [REG_SLOTS];
    logic [RESULT_W-1:0]   model_result_reg;
    bit                    model_halted;

    machine_result_t       pending_results [$];

    int  mismatch_count  = 0;
    int  items_sent      = 0;
    int  effective_items = 0;  // items that were not merely ignored by a halted machine
    int  results_checked = 0;
    int  status_seen [5];
    int  idle_cycles     = 0;

    // Sender pacing and receiver hold-off controls.
    int  burst_left      = 0;
    bit  steady_send     = 1'b0;
    bit  hold_pending    = 1'b0;

    register_machine_execute_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_instruction  (s_instruction),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_result_value (m_result_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Compute the response to one item and advance the predicted state.
    function automatic machine_result_t predict_item(input logic cmd,
                                                     input logic [INSTR_W-1:0] instr);
        logic [FIELD_W-1:0]   op;
        logic [FIELD_W-1:0]   ra;
        logic [FIELD_W-1:0]   rb;
        logic [FIELD_W-1:0]   rd;
        logic [RESULT_W-1:0]  a;
        logic [RESULT_W-1:0]  b;
        machine_result_t      r;
        r.status = ST_EXEC;
        if (cmd == CMD_RESET) begin
            foreach (model_regs[i]) model_regs[i] = '0;
            model_result_reg = '0;
            model_halted     = 1'b0;
        end else if (model_halted) begin
            r.status = ST_IGNORED;
        end else begin
            op = instr[OP_LSB +: FIELD_W];
            ra = instr[RA_LSB +: FIELD_W];
            rb = instr[RB_LSB +: FIELD_W];
            rd = instr[RD_LSB +: FIELD_W];
            a  = model_regs[ra];
            b  = model_regs[rb];
            case (op)
                OP_LDIMM:  model_regs[ra] = RESULT_W'(instr[IMM_W-1:0]);
                OP_ADD:    model_regs[rd] = a + b;
                OP_SUB:    model_regs[rd] = a - b;
                OP_MUL:    model_regs[rd] = a * b;
                OP_DIV: begin
                    if (b == '0) begin
                        model_halted = 1'b1;
                        r.status     = ST_DIVZ;
                    end else begin
                        model_regs[rd] = a / b;
                    end
                end
                OP_MOVRES: model_result_reg = a;
                OP_DONE: begin
                    model_halted = 1'b1;
                    r.status     = ST_DONE;
                end
                default: begin
                    model_halted = 1'b1;
                    r.status     = ST_UNKNOWN;
                end
            endcase
        end
        r.value = model_result_reg;
        return r;
    endfunction

    function automatic logic [INSTR_W-1:0] make_instr(input logic [FIELD_W-1:0] op,
                                                      input logic [FIELD_W-1:0] ra,
                                                      input logic [FIELD_W-1:0] rb,
                                                      input logic [FIELD_W-1:0] rd);
        return {op, ra, rb, rd};
    endfunction

    // Draw one instruction, weighted toward arithmetic that keeps the machine running.
    function automatic logic [INSTR_W-1:0] random_instruction();
        int                  sel;
        logic [FIELD_W-1:0]  ra;
        logic [FIELD_W-1:0]  rb;
        logic [FIELD_W-1:0]  rd;
        sel = $urandom_range(0, 99);
        ra  = FIELD_W'($urandom);
        rb  = FIELD_W'($urandom);
        rd  = FIELD_W'($urandom);
        if (sel < 22)      return make_instr(OP_LDIMM, ra, rb, rd);
        else if (sel < 36) return make_instr(OP_ADD, ra, rb, rd);
        else if (sel < 48) return make_instr(OP_SUB, ra, rb, rd);
        else if (sel < 60) return make_instr(OP_MUL, ra, rb, rd);
        else if (sel < 72) return make_instr(OP_DIV, ra, rb, rd);
        else if (sel < 91) return make_instr(OP_MOVRES, ra, rb, rd);
        else if (sel < 95) return make_instr(OP_DONE, ra, rb, rd);
        return make_instr(FIELD_W'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN)),
                          ra, rb, rd);
    endfunction

    // Offer one item, hold it until accepted, then record the expected response.
    // The sender runs in bursts; a gap drops valid for a random number of cycles.
    task automatic send_item(input logic cmd, input logic [INSTR_W-1:0] instr);
        int gap;
        if (!steady_send) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                // Now and then a long burst with no idling at all.
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
            end
            burst_left--;
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_instruction <= instr;
        do @(posedge aclk); while (!s_ready);
        if (!(cmd == CMD_EXECUTE && model_halted)) effective_items++;
        items_sent++;
        pending_results.push_back(predict_item(cmd, instr));
    endtask

    // Receiver: ready follows one of four patterns, redrawn at random by a phase counter;
    // a requested hold-off drops ready until a counter loaded from HOLD_CYCLES runs out.
    initial begin : receiver
        int hold_left;
        int phase_cnt;
        int mode;
        hold_left = 0;
        phase_cnt = 0;
        mode      = 0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                phase_cnt++;
                if (phase_cnt % 50 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (phase_cnt % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Check every accepted response against the oldest prediction and watch for
    // a stuck handshake.
    always @(posedge aclk) begin
        machine_result_t exp_item;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                    $display("Mismatches found");
                    $finish;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("response with no item outstanding: status %0d, value %h",
                           m_status, m_result_value);
                    mismatch_count++;
                end else begin
                    exp_item = pending_results.pop_front();
                    results_checked++;
                    if (int'(exp_item.status) < 5) status_seen[exp_item.status]++;
                    if (m_status !== exp_item.status) begin
                        $error("status: expected %0d, got %0d", exp_item.status, m_status);
                        mismatch_count++;
                    end
                    if (m_result_value !== exp_item.value) begin
                        $error("result_value: expected %h, got %h",
                               exp_item.value, m_result_value);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Loads at both ends of the immediate range, then read one back.
    task automatic test_load_extremes();
        send_item(CMD_RESET, '0);
        send_item(CMD_EXECUTE, {OP_LDIMM, 4'd0, 8'hFF});
        send_item(CMD_EXECUTE, {OP_LDIMM, 4'd15, 8'h00});
        send_item(CMD_EXECUTE, {OP_LDIMM, 4'd1, 8'h80});
        send_item(CMD_EXECUTE, make_instr(OP_MOVRES, 4'd0, 4'd0, 4'd0));
    endtask

    // Wrapping subtract, add and multiply, unsigned divide of a huge value,
    // and an all-ones register squared back to one.
    task automatic test_arithmetic();
        send_item(CMD_EXECUTE, make_instr(OP_SUB, 4'd15, 4'd0, 4'd2));
        send_item(CMD_EXECUTE, make_instr(OP_MUL, 4'd2, 4'd2, 4'd3));
        send_item(CMD_EXECUTE, make_instr(OP_ADD, 4'd3, 4'd2, 4'd4));
        send_item(CMD_EXECUTE, make_instr(OP_DIV, 4'd2, 4'd0, 4'd5));
        send_item(CMD_EXECUTE, make_instr(OP_MOVRES, 4'd5, 4'd0, 4'd0));
        send_item(CMD_EXECUTE, {OP_LDIMM, 4'd7, 8'h01});
        send_item(CMD_EXECUTE, make_instr(OP_SUB, 4'd15, 4'd7, 4'd8));
        send_item(CMD_EXECUTE, make_instr(OP_MUL, 4'd8, 4'd8, 4'd9));
        send_item(CMD_EXECUTE, make_instr(OP_MOVRES, 4'd8, 4'd0, 4'd0));
    endtask

    // Divide by a zero register halts; the next instruction is ignored.
    task automatic test_divide_by_zero();
        send_item(CMD_EXECUTE, make_instr(OP_DIV, 4'd0, 4'd15, 4'd10));
        send_item(CMD_EXECUTE, make_instr(OP_MOVRES, 4'd0, 4'd0, 4'd0));
        send_item(CMD_RESET, '1);
    endtask

    task automatic test_done_and_halt();
        send_item(CMD_EXECUTE, make_instr(OP_DONE, 4'd0, 4'd0, 4'd0));
        send_item(CMD_EXECUTE, '1);
        send_item(CMD_RESET, '0);
    endtask

    task automatic test_unknown_opcodes();
        send_item(CMD_EXECUTE, make_instr(OP_FIRST_UNKNOWN, 4'd0, 4'd0, 4'd0));
        send_item(CMD_RESET, '0);
        send_item(CMD_EXECUTE, make_instr(OP_LAST_UNKNOWN, 4'd1, 4'd2, 4'd3));
        send_item(CMD_RESET, '0);
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so the
    // core fills up and drops s_ready.
    task automatic test_backpressure();
        logic [FIELD_W-1:0] ra;
        steady_send  = 1'b1;
        hold_pending = 1'b1;
        send_item(CMD_RESET, '0);
        repeat (40) begin
            ra = FIELD_W'($urandom);
            case ($urandom_range(0, 3))
                0: send_item(CMD_EXECUTE, {OP_LDIMM, ra, 8'($urandom)});
                1: send_item(CMD_EXECUTE, make_instr(OP_ADD, ra, FIELD_W'($urandom),
                                                     FIELD_W'($urandom)));
                2: send_item(CMD_EXECUTE, make_instr(OP_SUB, ra, FIELD_W'($urandom),
                                                     FIELD_W'($urandom)));
                default: send_item(CMD_EXECUTE, make_instr(OP_MOVRES, ra, 4'd0, 4'd0));
            endcase
        end
        steady_send = 1'b0;
    endtask

    // Short random programs: reset if halted or by chance, run until halted or done, poke
    // the halted machine a few times, and occasionally reset mid-program.
    task automatic test_random_programs();
        int steps;
        while (items_sent < TARGET_ITEMS) begin
            if (model_halted || $urandom_range(0, 2) == 0)
                send_item(CMD_RESET, INSTR_W'($urandom));
            steps = $urandom_range(4, 40);
            for (int i = 0; i < steps && !model_halted; i++) begin
                if ($urandom_range(0, 49) == 0) send_item(CMD_RESET, INSTR_W'($urandom));
                else send_item(CMD_EXECUTE, random_instruction());
            end
            if (model_halted)
                repeat ($urandom_range(0, 3)) send_item(CMD_EXECUTE, INSTR_W'($urandom));
        end
    endtask

    initial begin : sequencer
        foreach (model_regs[i]) model_regs[i] = '0;
        model_result_reg = '0;
        model_halted     = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_load_extremes();
        test_arithmetic();
        test_divide_by_zero();
        test_done_and_halt();
        test_unknown_opcodes();
        test_backpressure();
        test_random_programs();

        // Drop valid, drain outstanding responses, then let the core settle.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d responses never arrived", pending_results.size());
            mismatch_count++;
        end

        $display("Sent %0d items (%0d not ignored), checked %0d responses",
                 items_sent, effective_items, results_checked);
        $display("Statuses: %0d executed, %0d done, %0d div-zero, %0d unknown, %0d ignored",
                 status_seen[ST_EXEC], status_seen[ST_DONE], status_seen[ST_DIVZ],
                 status_seen[ST_UNKNOWN], status_seen[ST_IGNORED]);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
